/* design/swm_pkg.sv */
package swm_pkg;

	// configuration register file
	localparam int unsigned LEN_W       = 4;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned CFG_ADDR_W  = 3;
	localparam logic [LEN_W-1:0] LEN_RESET = 4'd5;

	typedef enum logic [0:0] {
		REG_WINDOW_LENGTH = 1'b0
	} cfg_reg_t;

	// saturate the programmed length into 1..window_max
	function automatic logic [LEN_W:0] clamp_length(
		input logic [LEN_W-1:0] raw,
		input logic [LEN_W:0]   window_max
	);
		logic [LEN_W:0] ext;
		ext = {1'b0, raw};
		if (ext == '0) begin
			clamp_length = {{LEN_W{1'b0}}, 1'b1};
		end else if (ext > window_max) begin
			clamp_length = window_max;
		end else begin
			clamp_length = ext;
		end
	endfunction

endpackage

/* design/swm_cell.sv */
module swm_cell #(
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned POS_W       = 3,
	parameter int unsigned INDEX       = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          load,
	input  logic                          compact_active,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [POS_W-1:0]              pos,
	input  logic signed [SAMPLE_BITS-1:0] upper_val,
	input  logic [POS_W-1:0]              upper_tag,
	input  logic                          del_in,
	input  logic signed [SAMPLE_BITS-1:0] lower_cval,
	input  logic [POS_W-1:0]              lower_ctag,
	input  logic                          lower_ins,
	output logic signed [SAMPLE_BITS-1:0] val,
	output logic [POS_W-1:0]              tag,
	output logic                          del_out,
	output logic signed [SAMPLE_BITS-1:0] cval,
	output logic [POS_W-1:0]              ctag,
	output logic                          ins,
	output logic signed [SAMPLE_BITS-1:0] next_val
)
;
	logic signed [SAMPLE_BITS-1:0] val_q;
	logic [POS_W-1:0]              tag_q;
	logic [POS_W-1:0]              next_tag;

	assign val = val_q;
	assign tag = tag_q;

	// the retiring entry is dropped by pulling everything above it down one cell
	assign del_out = del_in | (tag_q == pos);
	assign cval    = del_out ? upper_val : val_q;
	assign ctag    = del_out ? upper_tag : tag_q;
	assign ins     = !compact_active || (cval > sample);

	// then the new sample goes in ahead of the first larger value
	always_comb begin
		if (!ins) begin
			next_val = cval;
			next_tag = ctag;
		end else if (lower_ins) begin
			next_val = lower_cval;
			next_tag = lower_ctag;
		end else begin
			next_val = sample;
			next_tag = pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			tag_q <= POS_W'(INDEX);
		end else if (clear) begin
			val_q <= '0;
			tag_q <= POS_W'(INDEX);
		end else if (load) begin
			val_q <= next_val;
			tag_q <= next_tag;
		end
	end

endmodule

/* design/sliding_window_median.sv */
// a request's median is registered as it is accepted and held on m_tdata until the next one
// throughput: one request per cycle unless a held result stalls s_tready; the sorted row
// of cells drops the oldest sample and inserts the new one in one pass through the chain
// a result waiting on m_tready holds off only while it is not taken in that same cycle
// reset: window cleared to zeros, write position zero, window_length 5, no result pending
module sliding_window_median #(
	parameter int unsigned WINDOW_MAX  = 8,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,  // sample
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,  // median
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [swm_pkg::CFG_ADDR_W-1:0]         paddr,
	input  logic [swm_pkg::CFG_DATA_W-1:0]         pwdata,
	output logic [swm_pkg::CFG_DATA_W-1:0]         prdata,
	output logic                                   pready
);
	import swm_pkg::*;

	localparam int unsigned DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int unsigned POS_W  = $clog2(WINDOW_MAX);

	logic [LEN_W-1:0]              len_q;
	logic [POS_W-1:0]              wpos_q;
	logic signed [SAMPLE_BITS-1:0] median_q;
	logic                          out_valid_q;

	logic                          cfg_write;
	logic                          clear;
	logic                          step;
	logic [LEN_W:0]                win_max;
	logic [LEN_W:0]                eff_len;
	logic [LEN_W:0]                pos_ext;
	logic [POS_W-1:0]              pos;
	logic [LEN_W:0]                pos_inc;
	logic [POS_W-1:0]              mid_idx;
	logic signed [SAMPLE_BITS-1:0] sample;

	logic signed [SAMPLE_BITS-1:0] val   [WINDOW_MAX];
	logic [POS_W-1:0]              tag   [WINDOW_MAX];
	logic                          del   [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] cval  [WINDOW_MAX];
	logic [POS_W-1:0]              ctag  [WINDOW_MAX];
	logic                          ins   [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] nval  [WINDOW_MAX];

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite
		&& (paddr[CFG_ADDR_W-1:2] == REG_WINDOW_LENGTH);
	assign clear     = cfg_write;
	assign prdata    = (paddr[CFG_ADDR_W-1:2] == REG_WINDOW_LENGTH)
		? {{(CFG_DATA_W-LEN_W){1'b0}}, len_q} : '0;

	assign s_tready = !out_valid_q || m_tready;
	assign step     = s_tvalid && s_tready;
	assign sample   = s_tdata[SAMPLE_BITS-1:0];

	assign win_max = (WINDOW_MAX > (2**LEN_W - 1)) ? (LEN_W+1)'(2**LEN_W - 1)
		: (LEN_W+1)'(WINDOW_MAX);
	assign eff_len = clamp_length(len_q, win_max);
	assign pos_ext = (LEN_W+1)'(wpos_q);
	assign pos     = (pos_ext >= eff_len) ? '0 : wpos_q;
	assign pos_inc = (LEN_W+1)'(pos) + 1'b1;
	assign mid_idx = POS_W'(eff_len >> 1);

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic                          load_i;
		logic                          cact_i;
		logic signed [SAMPLE_BITS-1:0] up_val;
		logic [POS_W-1:0]              up_tag;
		logic                          dn_del;
		logic signed [SAMPLE_BITS-1:0] dn_cval;
		logic [POS_W-1:0]              dn_ctag;
		logic                          dn_ins;

		assign load_i = step && ((LEN_W+1)'(i) < eff_len);
		assign cact_i = ((LEN_W+1)'(i + 1) < eff_len);

		if (i == WINDOW_MAX - 1) begin : g_top
			assign up_val = val[i];
			assign up_tag = tag[i];
		end else begin : g_mid
			assign up_val = val[i+1];
			assign up_tag = tag[i+1];
		end

		if (i == 0) begin : g_bot
			assign dn_del  = 1'b0;
			assign dn_cval = cval[i];
			assign dn_ctag = ctag[i];
			assign dn_ins  = 1'b0;
		end else begin : g_link
			assign dn_del  = del[i-1];
			assign dn_cval = cval[i-1];
			assign dn_ctag = ctag[i-1];
			assign dn_ins  = ins[i-1];
		end

		swm_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.POS_W      (POS_W),
			.INDEX      (i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.clear         (clear),
			.load          (load_i),
			.compact_active(cact_i),
			.sample        (sample),
			.pos           (pos),
			.upper_val     (up_val),
			.upper_tag     (up_tag),
			.del_in        (dn_del),
			.lower_cval    (dn_cval),
			.lower_ctag    (dn_ctag),
			.lower_ins     (dn_ins),
			.val           (val[i]),
			.tag           (tag[i]),
			.del_out       (del[i]),
			.cval          (cval[i]),
			.ctag          (ctag[i]),
			.ins           (ins[i]),
			.next_val      (nval[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LEN_RESET;
			wpos_q <= '0;
		end else if (cfg_write) begin
			len_q  <= pwdata[LEN_W-1:0];
			wpos_q <= '0;
		end else if (step) begin
			wpos_q <= (pos_inc >= eff_len) ? '0 : POS_W'(pos_inc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			median_q <= nval[mid_idx];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = DATA_W'($unsigned(median_q));

endmodule

/* tb/tb_sliding_window_median.sv */
`timescale 1ns / 1ps

module tb_sliding_window_median;
	import swm_pkg::*;

	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned WIN_DEPTH  = 8;
	localparam int unsigned MAX_WAIT   = 13;
	localparam int unsigned SETTLE_CYC = 4;
	localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW_LENGTH = CFG_ADDR_W'(4 * REG_WINDOW_LENGTH);
	// one past the register list, must be ignored
	localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = CFG_ADDR_W'(4);

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_LIGHT,
		IDLE_HEAVY
	} idle_mode_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [SAMPLE_W-1:0]    s_tdata;  // sample
	logic                   m_tvalid;
	logic                   m_tready;
	logic [SAMPLE_W-1:0]    m_tdata;  // median
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [CFG_ADDR_W-1:0]  paddr;
	logic [CFG_DATA_W-1:0]  pwdata;
	logic [CFG_DATA_W-1:0]  prdata;
	logic                   pready;

	logic [SAMPLE_W-1:0]        pending_samples [$];
	logic [SAMPLE_W-1:0]        expected_medians [$];
	logic signed [SAMPLE_W-1:0] window_model [WIN_DEPTH];
	logic [2:0]                 write_pos_model;
	logic [LEN_W-1:0]           length_model;

	idle_mode_t  send_mode;
	idle_mode_t  recv_mode;
	int unsigned send_gap;
	int unsigned recv_gap;
	int unsigned errors;
	int unsigned samples_sent;
	int unsigned results_seen;
	int unsigned reg_writes;

	sliding_window_median #(
		.WINDOW_MAX  (WIN_DEPTH),
		.SAMPLE_BITS (SAMPLE_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int unsigned draw_wait(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				return 0;
			end
			IDLE_LIGHT: begin
				return ($urandom_range(0, 5) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
			end
			default: begin
				return $urandom_range(0, MAX_WAIT);
			end
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			// narrow range so equal values pile up in the window
			3, 4: return SAMPLE_W'($signed($urandom_range(0, 6)) - 3);
			default: return r[SAMPLE_W-1:0];
		endcase
	endfunction

	// writes the sample at the ring position and picks index active/2 of the sorted window, length clamped to 1..WIN_DEPTH
	function automatic logic [SAMPLE_W-1:0] insert_and_select(input logic signed [SAMPLE_W-1:0] sample);
		logic signed [SAMPLE_W-1:0] sorted [WIN_DEPTH];
		logic signed [SAMPLE_W-1:0] v;
		int unsigned active;
		int unsigned pos;
		int unsigned i;
		int j;
		if (length_model == 0) begin
			active = 1;
		end else if (length_model > WIN_DEPTH) begin
			active = WIN_DEPTH;
		end else begin
			active = length_model;
		end
		pos = write_pos_model;
		if (pos >= active) begin
			pos = 0;
		end
		window_model[pos] = sample;
		pos++;
		if (pos >= active) begin
			pos = 0;
		end
		write_pos_model = 3'(pos);
		for (i = 0; i < active; i++) begin
			v = window_model[i];
			j = i;
			while (j > 0 && sorted[j-1] > v) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = v;
		end
		return sorted[active/2];
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap != 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_samples.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= pending_samples.pop_front();
				send_gap <= draw_wait(send_mode);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(posedge clk or negedge arst_n) begin
		int unsigned w;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else if (m_tvalid && m_tready) begin
			w = draw_wait(recv_mode);
			m_tready <= (w == 0);
			recv_gap <= (w == 0) ? 0 : w - 1;
		end else if (recv_gap != 0) begin
			m_tready <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// prediction and result checking; results are checked before new requests are predicted
	always @(posedge clk or negedge arst_n) begin
		logic [SAMPLE_W-1:0] want;
		if (!arst_n) begin
			foreach (window_model[k]) window_model[k] = '0;
			write_pos_model = '0;
			length_model = LEN_RESET;
			expected_medians.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_medians.size() == 0) begin
					$error("median: no result expected, got %0d", $signed(m_tdata));
					errors++;
				end else begin
					want = expected_medians.pop_front();
					if (m_tdata !== want) begin
						$error("median: expected %0d, got %0d", $signed(want), $signed(m_tdata));
						errors++;
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr == ADDR_WINDOW_LENGTH) begin
				length_model = pwdata[LEN_W-1:0];
				foreach (window_model[k]) window_model[k] = '0;
				write_pos_model = '0;
			end
			if (s_tvalid && s_tready) begin
				samples_sent++;
				expected_medians.push_back(insert_and_select(s_tdata));
			end
		end
	end

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [LEN_W-1:0] len_bits);
		logic [31:0] noise;
		noise = $urandom();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {noise[CFG_DATA_W-1:LEN_W], len_bits};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		reg_writes++;
		@(negedge clk);
	endtask

	// returns at a falling edge once every request has come back
	task automatic drain(input int unsigned settle);
		do @(negedge clk);
		while (pending_samples.size() != 0 || s_tvalid || expected_medians.size() != 0);
		repeat (settle) @(negedge clk);
	endtask

	task automatic queue_random(input int unsigned n);
		repeat (n) pending_samples.push_back(rand_sample());
	endtask

	initial begin : stimulus
		logic [LEN_W-1:0] sweep [8];
		int unsigned phase;
		int unsigned count;
		sweep = '{4'd8, 4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd9, 4'd1};
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		send_mode = IDLE_NONE;
		recv_mode = IDLE_NONE;
		errors = 0;
		samples_sent = 0;
		results_seen = 0;
		reg_writes = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset length: extremes and alternating bit patterns, zeros still in the window
		pending_samples.push_back(16'h7fff);
		pending_samples.push_back(16'h8000);
		pending_samples.push_back(16'h0000);
		pending_samples.push_back(16'hffff);
		pending_samples.push_back(16'h0001);
		pending_samples.push_back(16'h5555);
		pending_samples.push_back(16'haaaa);
		pending_samples.push_back(16'h8000);
		drain(SETTLE_CYC);

		// zero length behaves as one
		write_reg(ADDR_WINDOW_LENGTH, 4'd0);
		pending_samples.push_back(16'h8000);
		pending_samples.push_back(16'h7fff);
		pending_samples.push_back(16'h1234);
		drain(SETTLE_CYC);

		// all length bits set saturates to the full window
		recv_mode = IDLE_HEAVY;
		write_reg(ADDR_WINDOW_LENGTH, 4'd15);
		pending_samples.push_back(16'h7fff);
		pending_samples.push_back(16'h7fff);
		pending_samples.push_back(16'h8000);
		pending_samples.push_back(16'hffff);
		pending_samples.push_back(16'h7fff);
		drain(SETTLE_CYC);

		// a write past the register list must leave length and window alone
		send_mode = IDLE_HEAVY;
		write_reg(ADDR_UNMAPPED, 4'd2);
		pending_samples.push_back(16'h7fff);
		pending_samples.push_back(16'h0002);
		pending_samples.push_back(16'h8001);
		drain(SETTLE_CYC);

		for (phase = 0; phase < 14; phase++) begin
			write_reg(ADDR_WINDOW_LENGTH, (phase < 8) ? sweep[phase] : LEN_W'($urandom_range(0, 15)));
			if (phase == 0) begin
				send_mode = IDLE_NONE;
				recv_mode = IDLE_NONE;
			end else begin
				send_mode = idle_mode_t'($urandom_range(0, 2));
				recv_mode = idle_mode_t'($urandom_range(0, 2));
			end
			count = $urandom_range(90, 150);
			queue_random(count / 2);
			// sender holds off here until the window's results are all back
			drain(0);
			queue_random(count - count / 2);
			drain(SETTLE_CYC);
		end

		$display("swept %0d register writes with window lengths 0..15 over %0d samples",
			reg_writes, samples_sent);
		$display("%0d medians compared, %0d mismatches", results_seen, errors);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
